/* src/waaqp_pkg.sv */
// Shared types and constants for the weighted average air quality predictor.
// No dependencies; the interfaces, the top level and the testbench import this package.
`timescale 1ns / 1ps

package waaqp_pkg;

   localparam int ZONES_DEFAULT = 8;
   localparam int DAYS_DEFAULT  = 32;

   localparam int ZONE_W   = 3;
   localparam int GAS_W    = 20;
   localparam int WIND_W   = 16;
   localparam int FACTOR_W = 16;
   localparam int FRAC_W   = 14;
   localparam int DUST_W   = 19;
   localparam int VDAYS_W  = 6;
   localparam int ENTRY_W  = 4 * GAS_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 19;

   localparam logic [CSR_IDX_W-1:0] CSR_WIND_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR_WINDY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR_CALM    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_DUST     = 2'd3;

   localparam logic [WIND_W-1:0]   WIND_THRESHOLD_RST = 16'd1500;
   localparam logic [FACTOR_W-1:0] FACTOR_WINDY_RST   = 16'd12288;
   localparam logic [FACTOR_W-1:0] FACTOR_CALM_RST    = 16'd18022;
   localparam logic [DUST_W-1:0]   LIMIT_DUST_RST     = 19'd1500;
   localparam logic [DUST_W-1:0]   DUST_MAX           = 19'h7FFFF;

   // result jobs: prediction by reciprocal multiply first, then the four means on the divider
   localparam logic [2:0] JOB_PRED = 3'd0;
   localparam logic [2:0] JOB_LAST = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

/* src/waaqp_if.sv */
// Valid/ready channel interfaces for sample and result transactions.
// Depends on waaqp_pkg for field widths.
`timescale 1ns / 1ps

interface waaqp_req_if import waaqp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [ZONE_W-1:0]        zone;
   logic signed [GAS_W-1:0]  carbon_dioxide;
   logic signed [GAS_W-1:0]  sulfur_dioxide;
   logic signed [GAS_W-1:0]  nitrogen_dioxide;
   logic signed [GAS_W-1:0]  fine_dust;
   logic [WIND_W-1:0]        wind_speed;

   modport source (output valid, zone, carbon_dioxide, sulfur_dioxide, nitrogen_dioxide,
                   fine_dust, wind_speed, input ready);
   modport sink   (input valid, zone, carbon_dioxide, sulfur_dioxide, nitrogen_dioxide,
                   fine_dust, wind_speed, output ready);
endinterface

interface waaqp_rsp_if import waaqp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [DUST_W-1:0]        predicted_dust;
   logic                     critical;
   logic signed [GAS_W-1:0]  mean_co2;
   logic signed [GAS_W-1:0]  mean_so2;
   logic signed [GAS_W-1:0]  mean_no2;
   logic signed [GAS_W-1:0]  mean_dust;
   logic [VDAYS_W-1:0]       valid_days;

   modport source (output valid, predicted_dust, critical, mean_co2, mean_so2, mean_no2,
                   mean_dust, valid_days, input ready);
   modport sink   (input valid, predicted_dust, critical, mean_co2, mean_so2, mean_no2,
                   mean_dust, valid_days, output ready);
endinterface

/* src/waaqp_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; all widths are passed in as parameters.
`timescale 1ns / 1ps

module waaqp_divider #(
   parameter int DVD_W = 38,
   parameter int DSR_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DSR_W:0]   trial;
   logic [DSR_W:0]   diff;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[DSR_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DSR_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* src/weighted_average_air_quality_predictor_top.sv */
// Weighted average air quality predictor, top level.
// Each sample passes through the history scan over one memory read port, the bit-serial factor
// multiply, a two-step reciprocal multiply for the prediction and the shared one-bit-per-cycle
// divider for the four means; a sample with a bad zone goes straight to the result.
// One sample at a time.
// Reset is synchronous; afterwards a clearing pass over all ZONES*DAYS entries zeroes the history
// memory, during which no sample is taken (configuration writes still land).
`timescale 1ns / 1ps

module weighted_average_air_quality_predictor_top
   import waaqp_pkg::*;
#(
   parameter int ZONES = ZONES_DEFAULT,
   parameter int DAYS  = DAYS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   waaqp_req_if.sink             req_chan,
   waaqp_rsp_if.source           rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int W_TOTAL  = DAYS * (DAYS + 1) / 2;
   localparam int DSR_W    = $clog2(W_TOTAL + 1);
   localparam int DAY_BITS = $clog2(DAYS + 1);
   localparam int DIX_W    = $clog2(DAYS);
   localparam int WSUM_W   = GAS_W + DSR_W + 1;
   localparam int PROD_W   = WSUM_W - 1 + FACTOR_W;
   localparam int PQ_W     = PROD_W - FRAC_W;
   localparam int SUM_W    = GAS_W + DAY_BITS;
   localparam int DEPTH    = ZONES * DAYS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int ZIX_W    = (ZONES > 1) ? $clog2(ZONES) : 1;

   // reciprocal of the total weight: exact floor division for any quotient below 2^DUST_W
   localparam int RCP_L    = $clog2(W_TOTAL);
   localparam int RCP_X_W  = DUST_W + RCP_L;
   localparam int RCP_K    = RCP_X_W + RCP_L;
   localparam int RCP_M_W  = RCP_X_W + 1;
   localparam int RCP_LO_W = RCP_M_W / 2;
   localparam int RCP_HI_W = RCP_M_W - RCP_LO_W;
   localparam int RPH_W    = RCP_X_W + RCP_HI_W;
   localparam int RP_W     = RCP_X_W + RCP_M_W;
   localparam logic [RCP_M_W-1:0] RCP_M =
      RCP_M_W'(((64'd1 << RCP_K) + 64'(W_TOTAL) - 64'd1) / 64'(W_TOTAL));
   localparam logic [RCP_LO_W-1:0] RCP_M_LO = RCP_M[RCP_LO_W-1:0];
   localparam logic [RCP_HI_W-1:0] RCP_M_HI = RCP_M[RCP_M_W-1:RCP_LO_W];
   localparam logic [PQ_W-1:0]     SAT_LIM  = PQ_W'(64'(W_TOTAL) << DUST_W);

   // configuration registers
   logic [WIND_W-1:0]   wind_thr_ff;
   logic [FACTOR_W-1:0] fac_windy_ff;
   logic [FACTOR_W-1:0] fac_calm_ff;
   logic [DUST_W-1:0]   limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wind_thr_ff  <= WIND_THRESHOLD_RST;
         fac_windy_ff <= FACTOR_WINDY_RST;
         fac_calm_ff  <= FACTOR_CALM_RST;
         limit_ff     <= LIMIT_DUST_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIND_THRESHOLD: wind_thr_ff  <= csr_wdata[WIND_W-1:0];
            CSR_FACTOR_WINDY:   fac_windy_ff <= csr_wdata[FACTOR_W-1:0];
            CSR_FACTOR_CALM:    fac_calm_ff  <= csr_wdata[FACTOR_W-1:0];
            CSR_LIMIT_DUST:     limit_ff     <= csr_wdata[DUST_W-1:0];
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;

   // history: one ring buffer per zone, head points at the newest day
   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;
   logic [DIX_W-1:0]   head_ff [ZONES];
   logic [ADDR_W-1:0]  clr_ff;

   logic [ADDR_W-1:0]  base_ff;
   logic [ZIX_W-1:0]   zix_ff;
   logic [ENTRY_W-1:0] sample_ff;
   logic [FACTOR_W-1:0] factor_ff;
   logic [DIX_W-1:0]   idx_ff;
   logic [DAY_BITS-1:0] cnt_ff;
   logic [DAY_BITS-1:0] wt_ff;
   logic               pend_ff;
   logic [DAY_BITS-1:0] vcnt_ff;

   logic signed [WSUM_W-1:0] wsum_ff;
   logic signed [SUM_W-1:0]  sum_ff [4];
   logic [PROD_W-1:0]        acc_ff;
   logic [3:0]               mstep_ff;
   logic [2:0]               job_ff;
   logic                     started_ff;
   logic                     rstep_ff;
   logic [RPH_W-1:0]         rp_lo_ff;

   logic [DUST_W-1:0]       pred_ff;
   logic signed [GAS_W-1:0] mean_ff [4];

   logic                    rsp_valid_ff;
   logic [DUST_W-1:0]       rsp_pred_ff;
   logic                    rsp_crit_ff;
   logic signed [GAS_W-1:0] rsp_mean_ff [4];
   logic [VDAYS_W-1:0]      rsp_vdays_ff;

   // control decode
   logic req_ready, mem_we, rd_issue, div_start, rsp_load, accept, zone_ok;
   logic div_done;
   logic [SUM_W-1:0] div_quo;

   assign accept  = req_chan.valid && req_ready;
   assign zone_ok = (32'(req_chan.zone) < ZONES);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == ADDR_W'(DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = zone_ok ? ST_WRITE : ST_DONE;
         ST_WRITE: state_in = ST_SCAN;
         ST_SCAN:  if (cnt_ff == DAY_BITS'(DAYS)) state_in = ST_MUL;
         ST_MUL:   if (mstep_ff == 4'd15) state_in = ST_DIV;
         ST_DIV:   if (div_done && job_ff == JOB_LAST) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mem_we    = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
      rd_issue  = (state_ff == ST_SCAN) && (cnt_ff != DAY_BITS'(DAYS));
      div_start = (state_ff == ST_DIV) && (job_ff != JOB_PRED) && !started_ff;
      rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   // memory port
   logic [DIX_W-1:0]   new_head;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   assign new_head = (head_ff[zix_ff] == '0) ? DIX_W'(DAYS - 1) : head_ff[zix_ff] - 1'b1;
   assign wr_addr  = (state_ff == ST_CLEAR) ? clr_ff : base_ff + ADDR_W'(new_head);
   assign wr_data  = (state_ff == ST_CLEAR) ? '0 : sample_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[base_ff + ADDR_W'(idx_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         for (int z = 0; z < ZONES; z++) head_ff[z] <= '0;
      end else begin
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_WRITE) head_ff[zix_ff] <= new_head;
      end
   end

   // one history day: values and weighted dust term
   logic signed [GAS_W-1:0]      day_val [4];
   logic                         day_ok;
   logic signed [GAS_W+DAY_BITS:0] wterm;

   always_comb begin
      for (int i = 0; i < 4; i++) day_val[i] = rdata_ff[ENTRY_W-1-i*GAS_W -: GAS_W];
      day_ok = 1'b0;
      for (int i = 0; i < 4; i++) day_ok = day_ok || (day_val[i] > 0);
      wterm = day_val[3] * $signed({1'b0, wt_ff});
   end

   // divider operands (means only)
   logic [1:0]        mix;
   logic              sum_neg;
   logic [SUM_W-1:0]  sum_mag;
   logic [GAS_W-1:0]  q20;
   logic [WSUM_W-2:0] mcand;

   assign mix     = 2'(job_ff - 3'd1);
   assign sum_neg = sum_ff[mix][SUM_W-1];
   assign sum_mag = sum_neg ? SUM_W'(-sum_ff[mix]) : SUM_W'(sum_ff[mix]);
   assign q20     = div_quo[GAS_W-1:0];
   assign mcand   = (wsum_ff > 0) ? wsum_ff[WSUM_W-2:0] : '0;

   waaqp_divider #(
      .DVD_W (SUM_W),
      .DSR_W (DAY_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (vcnt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // prediction divide by the total weight: saturate check, then one multiplier used twice,
   // low half of the reciprocal first, high half next
   logic [PQ_W-1:0]     pq;
   logic                pq_sat;
   logic [RCP_X_W-1:0]  pq_lo;
   logic [RCP_HI_W-1:0] rcp_sel;
   logic [RPH_W-1:0]    rp_part;
   logic [RP_W-1:0]     rp_full;

   assign pq      = acc_ff[PROD_W-1:FRAC_W];
   assign pq_sat  = (pq >= SAT_LIM);
   assign pq_lo   = pq[RCP_X_W-1:0];
   assign rcp_sel = rstep_ff ? RCP_M_HI : RCP_HI_W'(RCP_M_LO);
   assign rp_part = RPH_W'(pq_lo) * RPH_W'(rcp_sel);
   assign rp_full = RP_W'(rp_lo_ff) + {rp_part, {RCP_LO_W{1'b0}}};

   // sequencer datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         started_ff <= 1'b0;
         rstep_ff   <= 1'b0;
      end else begin
         pend_ff  <= rd_issue;
         rstep_ff <= (state_ff == ST_DIV) && (job_ff == JOB_PRED) && !rstep_ff;
         if (div_start) started_ff <= 1'b1;
         else if (div_done) started_ff <= 1'b0;
      end

      if (accept) begin
         zix_ff    <= ZIX_W'(req_chan.zone);
         base_ff   <= ADDR_W'(ZIX_W'(req_chan.zone)) * ADDR_W'(DAYS);
         sample_ff <= {req_chan.carbon_dioxide, req_chan.sulfur_dioxide,
                       req_chan.nitrogen_dioxide, req_chan.fine_dust};
         factor_ff <= (req_chan.wind_speed > wind_thr_ff) ? fac_windy_ff : fac_calm_ff;
         cnt_ff    <= '0;
         vcnt_ff   <= '0;
         wsum_ff   <= '0;
         acc_ff    <= '0;
         mstep_ff  <= '0;
         job_ff    <= JOB_PRED;
         pred_ff   <= '0;
         for (int i = 0; i < 4; i++) begin
            sum_ff[i]  <= '0;
            mean_ff[i] <= '0;
         end
      end

      if (state_ff == ST_WRITE) idx_ff <= new_head;

      if (rd_issue) begin
         wt_ff  <= DAY_BITS'(DAYS) - cnt_ff;
         cnt_ff <= cnt_ff + 1'b1;
         idx_ff <= (idx_ff == DIX_W'(DAYS - 1)) ? '0 : idx_ff + 1'b1;
      end

      if (pend_ff) begin
         wsum_ff <= wsum_ff + WSUM_W'(wterm);
         if (day_ok) begin
            vcnt_ff <= vcnt_ff + 1'b1;
            for (int i = 0; i < 4; i++) sum_ff[i] <= sum_ff[i] + SUM_W'(day_val[i]);
         end
      end

      // factor multiply, MSB of the factor first
      if (state_ff == ST_MUL) begin
         acc_ff   <= (acc_ff << 1) + (factor_ff[~mstep_ff] ? PROD_W'(mcand) : '0);
         mstep_ff <= mstep_ff + 1'b1;
      end

      if (state_ff == ST_DIV && job_ff == JOB_PRED) begin
         if (!rstep_ff) begin
            rp_lo_ff <= rp_part;
         end else begin
            pred_ff <= pq_sat ? DUST_MAX : rp_full[RCP_K +: DUST_W];
            job_ff  <= job_ff + 1'b1;
         end
      end

      if (state_ff == ST_DIV && div_done) begin
         job_ff <= job_ff + 1'b1;
         if (vcnt_ff != '0) begin
            mean_ff[mix] <= sum_neg ? -q20 : q20;
         end
      end
   end

   // result register; a new sample is taken while a result waits here
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_pred_ff  <= pred_ff;
         rsp_crit_ff  <= (pred_ff > limit_ff);
         rsp_vdays_ff <= VDAYS_W'(vcnt_ff);
         for (int i = 0; i < 4; i++) rsp_mean_ff[i] <= mean_ff[i];
      end
   end

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.predicted_dust = rsp_pred_ff;
   assign rsp_chan.critical       = rsp_crit_ff;
   assign rsp_chan.mean_co2       = rsp_mean_ff[0];
   assign rsp_chan.mean_so2       = rsp_mean_ff[1];
   assign rsp_chan.mean_no2       = rsp_mean_ff[2];
   assign rsp_chan.mean_dust      = rsp_mean_ff[3];
   assign rsp_chan.valid_days     = rsp_vdays_ff;
endmodule

/* dv/tb_weighted_average_air_quality_predictor_top.sv */
// Testbench for the weighted average air quality predictor top level.
// Drives random and directed samples, predicts each result with a local model and checks it.
// Depends on waaqp_pkg, waaqp_if and the top level RTL.
`timescale 1ns / 1ps

module tb_weighted_average_air_quality_predictor_top;
   import waaqp_pkg::*;

   localparam int ZONES = ZONES_DEFAULT;
   localparam int DAYS  = DAYS_DEFAULT;
   localparam int TOTAL_WEIGHT = DAYS * (DAYS + 1) / 2;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [ZONE_W-1:0]       zone;
      logic signed [GAS_W-1:0] co2;
      logic signed [GAS_W-1:0] so2;
      logic signed [GAS_W-1:0] no2;
      logic signed [GAS_W-1:0] dust;
      logic [WIND_W-1:0]       wind;
   } sample_type;

   typedef struct packed {
      logic [DUST_W-1:0]       predicted_dust;
      logic                    critical;
      logic signed [GAS_W-1:0] mean_co2;
      logic signed [GAS_W-1:0] mean_so2;
      logic signed [GAS_W-1:0] mean_no2;
      logic signed [GAS_W-1:0] mean_dust;
      logic [VDAYS_W-1:0]      valid_days;
   } forecast_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_WIND_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   waaqp_req_if req_chan ();
   waaqp_rsp_if rsp_chan ();

   weighted_average_air_quality_predictor_top #(.ZONES(ZONES), .DAYS(DAYS)) dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state: per-zone history, newest day at index 0
   logic signed [GAS_W-1:0] hist [ZONES][DAYS][4];
   logic [WIND_W-1:0]   wind_thr;
   logic [FACTOR_W-1:0] fac_windy, fac_calm;
   logic [DUST_W-1:0]   dust_limit;

   sample_type   pending_samples[$];
   forecast_type expected_forecasts[$];
   int  errors = 0;
   bit  quiet = 0;      // last part of run: no idling
   bit  hold_off = 0;   // long receiver stall requested
   bit  stim_done = 0;

   // shift one sample into its zone and work out the transaction it should produce
   function automatic forecast_type forecast_sample(sample_type s);
      forecast_type f;
      longint wsum, sums[4], q;
      int valid;
      logic [FACTOR_W-1:0] fac;
      f = '0;
      wsum = 0; valid = 0;
      for (int i = 0; i < 4; i++) sums[i] = 0;
      if (s.zone >= ZONES) return f;
      for (int d = DAYS - 1; d > 0; d--)
         for (int i = 0; i < 4; i++) hist[s.zone][d][i] = hist[s.zone][d-1][i];
      hist[s.zone][0][0] = s.co2;
      hist[s.zone][0][1] = s.so2;
      hist[s.zone][0][2] = s.no2;
      hist[s.zone][0][3] = s.dust;
      for (int d = 0; d < DAYS; d++) begin
         wsum += longint'(hist[s.zone][d][3]) * (DAYS - d);
         if (hist[s.zone][d][0] > 0 || hist[s.zone][d][1] > 0 ||
             hist[s.zone][d][2] > 0 || hist[s.zone][d][3] > 0) begin
            for (int i = 0; i < 4; i++) sums[i] += hist[s.zone][d][i];
            valid++;
         end
      end
      fac = (s.wind > wind_thr) ? fac_windy : fac_calm;
      if (wsum > 0) begin
         q = (wsum * longint'(fac)) / (longint'(TOTAL_WEIGHT) << FRAC_W);
         f.predicted_dust = (q > longint'(DUST_MAX)) ? DUST_MAX : q[DUST_W-1:0];
      end
      f.critical = f.predicted_dust > dust_limit;
      if (valid > 0) begin
         q = sums[0] / valid; f.mean_co2  = q[GAS_W-1:0];
         q = sums[1] / valid; f.mean_so2  = q[GAS_W-1:0];
         q = sums[2] / valid; f.mean_no2  = q[GAS_W-1:0];
         q = sums[3] / valid; f.mean_dust = q[GAS_W-1:0];
      end
      f.valid_days = valid[VDAYS_W-1:0];
      return f;
   endfunction

   // ---------------- driver ----------------
   int  send_gap = 0;
   initial begin
      req_chan.valid = 1'b0;
      req_chan.zone = '0;
      req_chan.carbon_dioxide = '0;
      req_chan.sulfur_dioxide = '0;
      req_chan.nitrogen_dioxide = '0;
      req_chan.fine_dust = '0;
      req_chan.wind_speed = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         // a transaction completes on this edge when valid and ready were both high
         if (req_chan.valid && req_chan.ready) begin
            sample_type s;
            s = {req_chan.zone, req_chan.carbon_dioxide, req_chan.sulfur_dioxide,
                 req_chan.nitrogen_dioxide, req_chan.fine_dust, req_chan.wind_speed};
            expected_forecasts.push_back(forecast_sample(s));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               sample_type s;
               s = pending_samples.pop_front();
               req_chan.valid            <= 1'b1;
               req_chan.zone             <= s.zone;
               req_chan.carbon_dioxide   <= s.co2;
               req_chan.sulfur_dioxide   <= s.so2;
               req_chan.nitrogen_dioxide <= s.no2;
               req_chan.fine_dust        <= s.dust;
               req_chan.wind_speed       <= s.wind;
               // random bursts of sender idling
               if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 7);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor / checker ----------------
   int recv_gap = 0;
   initial rsp_chan.ready = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            forecast_type e;
            if (expected_forecasts.size() == 0) begin
               $error("unexpected result transaction");
               errors++;
            end else begin
               e = expected_forecasts.pop_front();
               if (rsp_chan.predicted_dust !== e.predicted_dust) begin
                  $error("predicted_dust exp %0d got %0d", e.predicted_dust,
                         rsp_chan.predicted_dust);
                  errors++;
               end
               if (rsp_chan.critical !== e.critical) begin
                  $error("critical exp %0d got %0d", e.critical, rsp_chan.critical);
                  errors++;
               end
               if (rsp_chan.mean_co2 !== e.mean_co2) begin
                  $error("mean_co2 exp %0d got %0d", e.mean_co2, rsp_chan.mean_co2);
                  errors++;
               end
               if (rsp_chan.mean_so2 !== e.mean_so2) begin
                  $error("mean_so2 exp %0d got %0d", e.mean_so2, rsp_chan.mean_so2);
                  errors++;
               end
               if (rsp_chan.mean_no2 !== e.mean_no2) begin
                  $error("mean_no2 exp %0d got %0d", e.mean_no2, rsp_chan.mean_no2);
                  errors++;
               end
               if (rsp_chan.mean_dust !== e.mean_dust) begin
                  $error("mean_dust exp %0d got %0d", e.mean_dust, rsp_chan.mean_dust);
                  errors++;
               end
               if (rsp_chan.valid_days !== e.valid_days) begin
                  $error("valid_days exp %0d got %0d", e.valid_days, rsp_chan.valid_days);
                  errors++;
               end
            end
         end
         // receiver stalls: a long hold-off on request, else short random bursts
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            recv_gap <= $urandom_range(0, 6);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ---------------- watchdog ----------------
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || hold_off)
         idle_cycles <= 0;
      else if (!stim_done || req_chan.valid || pending_samples.size() > 0
               || expected_forecasts.size() > 0)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[weighted_average_air_quality_predictor_top] ERROR");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic signed [GAS_W-1:0] rand_gas();
      case ($urandom_range(0, 5))
         0: return -$signed(GAS_W'($urandom_range(0, 2000)));
         1: return GAS_W'($urandom_range(0, 524287));
         2: return GAS_W'($urandom);
         3: return '0;
         default: return GAS_W'($urandom_range(0, 5000));
      endcase
   endfunction

   function automatic sample_type rand_sample();
      sample_type s;
      s.zone = $urandom_range(0, 2) == 0 ? ZONE_W'($urandom) : ZONE_W'($urandom_range(0, 2));
      s.co2  = rand_gas();
      s.so2  = rand_gas();
      s.no2  = rand_gas();
      s.dust = rand_gas();
      s.wind = $urandom_range(0, 3) == 0 ? WIND_W'($urandom) : WIND_W'($urandom_range(0, 3000));
      return s;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WIND_THRESHOLD: wind_thr   = v[WIND_W-1:0];
         CSR_FACTOR_WINDY:   fac_windy  = v[FACTOR_W-1:0];
         CSR_FACTOR_CALM:    fac_calm   = v[FACTOR_W-1:0];
         default:            dust_limit = v;
      endcase
   endtask

   task automatic drain();
      wait (pending_samples.size() == 0 && !req_chan.valid && expected_forecasts.size() == 0);
      repeat (300) @(posedge clock);
   endtask

   task automatic load_random(input int n);
      for (int i = 0; i < n; i++) pending_samples.push_back(rand_sample());
   endtask

   initial begin
      sample_type s;
      for (int z = 0; z < ZONES; z++)
         for (int d = 0; d < DAYS; d++)
            for (int i = 0; i < 4; i++) hist[z][d][i] = '0;
      wind_thr = WIND_THRESHOLD_RST; fac_windy = FACTOR_WINDY_RST;
      fac_calm = FACTOR_CALM_RST;    dust_limit = LIMIT_DUST_RST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, saturation, negative sums, empty days, wind on both sides
      s = '{zone: 0, co2: 0, so2: 0, no2: 0, dust: 0, wind: 0};
      pending_samples.push_back(s);                              // no valid day
      s = '{zone: 0, co2: 20'h7FFFF, so2: 20'h7FFFF, no2: 20'h7FFFF, dust: 20'h7FFFF,
            wind: 16'hFFFF};
      repeat (3) pending_samples.push_back(s);                   // maximum values
      s = '{zone: 1, co2: 20'h80000, so2: 20'h80000, no2: 20'h80000, dust: 20'h80000,
            wind: 0};
      repeat (2) pending_samples.push_back(s);                   // negative weighted sum
      s = '{zone: 1, co2: -5, so2: -5, no2: -5, dust: 7, wind: 1500};
      pending_samples.push_back(s);                              // wind at the threshold
      s.wind = 1501;
      pending_samples.push_back(s);                              // just above threshold
      s = '{zone: 2, co2: -100, so2: 3, no2: -100, dust: -100, wind: 16'h5555};
      pending_samples.push_back(s);                              // valid by one field
      s = '{zone: 3'd7, co2: 20'h7FFFF, so2: 20'h7FFFF, no2: 20'h7FFFF, dust: 20'h7FFFF,
            wind: 16'hAAAA};
      pending_samples.push_back(s);                              // highest zone
      for (int i = 0; i < 34; i++) begin                         // fill a full history
         s = '{zone: 3, co2: GAS_W'(100 * i), so2: GAS_W'(-i), no2: 5,
               dust: GAS_W'(20'h7FFFF - i), wind: 100};
         pending_samples.push_back(s);
      end
      drain();

      // extreme settings, then a long receiver stall while samples queue up
      write_csr(CSR_WIND_THRESHOLD, '0);
      write_csr(CSR_FACTOR_WINDY, CSR_DATA_W'(16'hFFFF));
      write_csr(CSR_FACTOR_CALM, '0);
      write_csr(CSR_LIMIT_DUST, '0);
      load_random(250);
      fork
         begin
            hold_off = 1;
            repeat (2000) @(posedge clock);
            hold_off = 0;
         end
      join_none
      drain();

      write_csr(CSR_WIND_THRESHOLD, CSR_DATA_W'(16'hFFFF));
      write_csr(CSR_FACTOR_WINDY, '0);
      write_csr(CSR_FACTOR_CALM, CSR_DATA_W'(16'hFFFF));
      write_csr(CSR_LIMIT_DUST, DUST_MAX);
      load_random(250);
      drain();

      write_csr(CSR_WIND_THRESHOLD, CSR_DATA_W'($urandom_range(0, 3000)));
      write_csr(CSR_FACTOR_WINDY, CSR_DATA_W'($urandom));
      write_csr(CSR_FACTOR_CALM, CSR_DATA_W'($urandom));
      write_csr(CSR_LIMIT_DUST, CSR_DATA_W'($urandom_range(0, 20000)));
      load_random(350);
      drain();

      // last part runs without idling
      write_csr(CSR_WIND_THRESHOLD, CSR_DATA_W'(WIND_THRESHOLD_RST));
      write_csr(CSR_FACTOR_WINDY, CSR_DATA_W'(FACTOR_WINDY_RST));
      write_csr(CSR_FACTOR_CALM, CSR_DATA_W'(FACTOR_CALM_RST));
      write_csr(CSR_LIMIT_DUST, LIMIT_DUST_RST);
      quiet = 1;
      load_random(250);
      stim_done = 1;
      drain();

      if (errors == 0)
         $display("[weighted_average_air_quality_predictor_top] OK");
      else
         $display("[weighted_average_air_quality_predictor_top] ERROR");
      $finish;
   end

endmodule

/* sim.f */
src/waaqp_pkg.sv
src/waaqp_if.sv
src/waaqp_divider.sv
src/weighted_average_air_quality_predictor_top.sv
dv/tb_weighted_average_air_quality_predictor_top.sv
